### rtl/core/tcpq_pkg.sv
// tcpq_pkg: operation codes, field widths and the queue entry type
// for the two-class priority queue. No dependencies.
`timescale 1ns / 1ps

package tcpq_pkg;

  localparam int ITEM_ID_W = 10;
  localparam int COUNT_W   = 5;

  // Highest id that the queue takes; ids are compared at this width.
  localparam int             ID_CMP_W    = 16;
  localparam logic [15:0]    MAX_ITEM_ID = 16'd1023;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DEPART = 2'd1,
    OP_REMOVE = 2'd2,
    OP_LOOKUP = 2'd3
  } op_t;

  typedef struct packed {
    logic                 urgent;
    logic [ITEM_ID_W-1:0] id;
  } entry_t;

endpackage

### rtl/core/two_class_priority_queue.sv
// two_class_priority_queue: bounded two-class queue with unique ids.
// Depends on tcpq_pkg (op codes, entry type, widths).
`timescale 1ns / 1ps

//--------------------------------------------------------------------------
// Usage
//   Input stream: one transaction per operation. in_tuser carries the
//   operation (add, depart head, remove by id, lookup); in_tdata carries
//   the id, the urgent flag and the item type. Every operation returns
//   exactly one result transaction on the out_ stream with status, found,
//   departed id and both counts after the operation.
//   cfg_we/cfg_wdata set the accepted item type; write only while idle.
//   Structure: the queue sits in a single-port memory; one shared
//   compare unit walks the entries and every move of an entry costs one
//   read and one write. A search steps through S_RDREQ and S_CMP for each
//   entry visited, a shift through S_MVRD and S_MVWR for each entry moved;
//   an add then writes the new entry in S_INS. A rejected op goes straight
//   to S_FIN, which stages the result in the output register.
//   in_tready is high only while the sequencer is idle. A finished result
//   sits in an output register, so the next transaction is accepted while
//   the result waits; if the receiver stalls and a second result is done,
//   the sequencer holds until the output register frees up.
//   Reset (rst_n low, synchronous) empties the queue, clears the output
//   register and sets the accepted type to domestic. Memory contents are
//   not cleared: only entries below the occupancy are ever read.
//--------------------------------------------------------------------------
module two_class_priority_queue
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,     // queue_type
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // item_id[9:0], urgent[10], item_type[11], zero pad
  input  logic [1:0]  in_tuser,      // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata      // status[0], found[1], departed_id[11:2],
                                     // total_count[16:12], urgent_count[21:17], zero pad
);

  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RDREQ = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_MVRD  = 7'b0001000,
    S_MVWR  = 7'b0010000,
    S_INS   = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic                 qtype_r;
  logic [CNT_W-1:0]     occ_r, occ_nxt;
  logic [CNT_W-1:0]     uocc_r, uocc_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  op_t                  op_r, op_nxt;
  logic [ITEM_ID_W-1:0] id_r, id_nxt;
  logic                 urg_r, urg_nxt;
  logic                 dir_up_r, dir_up_nxt;
  logic                 hit_urg_r, hit_urg_nxt;
  logic                 status_r, status_nxt;
  logic                 found_r, found_nxt;
  logic [ITEM_ID_W-1:0] dep_r, dep_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [23:0]          out_data_r, out_data_nxt;

  // single-port queue memory
  entry_t               mem [QUEUE_DEPTH];
  entry_t               rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 mem_we;
  logic [ADDR_W-1:0]    wr_addr;
  entry_t               wr_data;

  logic                 in_fire;
  op_t                  in_op;
  logic [ITEM_ID_W-1:0] in_id;
  logic                 in_urg, in_type, in_id_ok;
  logic [CNT_W:0]       idx_inc;
  logic [CNT_W-1:0]     idx_dec;
  logic [CNT_W-1:0]     ins_pos;
  logic                 cmp_hit;
  logic                 out_load;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_op     = op_t'(in_tuser);
  assign in_id     = in_tdata[ITEM_ID_W-1:0];
  assign in_urg    = in_tdata[ITEM_ID_W];
  assign in_type   = in_tdata[ITEM_ID_W+1];
  assign in_id_ok  = (in_id != '0) && (ID_CMP_W'(in_id) <= MAX_ITEM_ID);

  assign idx_inc   = {1'b0, idx_r} + 1'b1;
  assign idx_dec   = idx_r - 1'b1;
  // urgent items go right after the urgent block, normal ones at the tail
  assign ins_pos   = urg_r ? uocc_r : occ_r;
  // depart always takes the head, which is the first entry compared
  assign cmp_hit   = (op_r == OP_DEPART) || (rd_data_r.id == id_r);
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt   = state_r;
    occ_nxt     = occ_r;
    uocc_nxt    = uocc_r;
    idx_nxt     = idx_r;
    op_nxt      = op_r;
    id_nxt      = id_r;
    urg_nxt     = urg_r;
    dir_up_nxt  = dir_up_r;
    hit_urg_nxt = hit_urg_r;
    status_nxt  = status_r;
    found_nxt   = found_r;
    dep_nxt     = dep_r;
    rd_addr     = idx_r[ADDR_W-1:0];
    mem_we      = 1'b0;
    wr_addr     = idx_r[ADDR_W-1:0];
    wr_data     = rd_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_op;
          id_nxt      = in_id;
          urg_nxt     = in_urg;
          idx_nxt     = '0;
          dir_up_nxt  = 1'b0;
          hit_urg_nxt = 1'b0;
          status_nxt  = 1'b1;
          found_nxt   = 1'b0;
          dep_nxt     = '0;
          state_nxt   = S_FIN;
          unique case (in_op)
            OP_ADD: begin
              if (in_id_ok && (in_type == qtype_r) &&
                  (occ_r != CNT_W'(QUEUE_DEPTH))) begin
                if (occ_r == '0) begin
                  // nothing to search: open the slot directly
                  dir_up_nxt = 1'b1;
                  idx_nxt    = occ_r;
                  state_nxt  = S_MVRD;
                end else begin
                  state_nxt = S_RDREQ;
                end
              end
            end
            OP_DEPART: begin
              if (occ_r != '0) state_nxt = S_RDREQ;
            end
            OP_REMOVE: begin
              if (in_id_ok && (occ_r != '0)) state_nxt = S_RDREQ;
            end
            OP_LOOKUP: begin
              if (in_id_ok) begin
                status_nxt = 1'b0;
                if (occ_r != '0) state_nxt = S_RDREQ;
              end
            end
            default: ;
          endcase
        end
      end

      S_RDREQ: begin
        // read address idx_r is presented this cycle
        state_nxt = S_CMP;
      end

      S_CMP: begin
        if (cmp_hit) begin
          hit_urg_nxt = rd_data_r.urgent;
          unique case (op_r)
            OP_ADD: begin
              state_nxt = S_FIN;  // duplicate id
            end
            OP_DEPART: begin
              dep_nxt   = rd_data_r.id;
              state_nxt = S_MVRD;
            end
            OP_REMOVE: begin
              state_nxt = S_MVRD;
            end
            OP_LOOKUP: begin
              found_nxt = 1'b1;
              state_nxt = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end else if (idx_inc == {1'b0, occ_r}) begin
          // searched every entry without a hit
          if (op_r == OP_ADD) begin
            dir_up_nxt = 1'b1;
            idx_nxt    = occ_r;
            state_nxt  = S_MVRD;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          idx_nxt   = idx_inc[CNT_W-1:0];
          state_nxt = S_RDREQ;
        end
      end

      S_MVRD: begin
        if (dir_up_r) begin
          if (idx_r == ins_pos) begin
            state_nxt = S_INS;
          end else begin
            rd_addr   = idx_dec[ADDR_W-1:0];
            state_nxt = S_MVWR;
          end
        end else begin
          if (idx_inc >= {1'b0, occ_r}) begin
            // entries behind the removed one have closed up
            occ_nxt    = occ_r - 1'b1;
            if (hit_urg_r && (uocc_r != '0)) uocc_nxt = uocc_r - 1'b1;
            status_nxt = 1'b0;
            state_nxt  = S_FIN;
          end else begin
            rd_addr   = idx_inc[ADDR_W-1:0];
            state_nxt = S_MVWR;
          end
        end
      end

      S_MVWR: begin
        mem_we    = 1'b1;
        wr_addr   = idx_r[ADDR_W-1:0];
        wr_data   = rd_data_r;
        idx_nxt   = dir_up_r ? idx_dec : idx_inc[CNT_W-1:0];
        state_nxt = S_MVRD;
      end

      S_INS: begin
        mem_we         = 1'b1;
        wr_addr        = idx_r[ADDR_W-1:0];
        wr_data.urgent = urg_r;
        wr_data.id     = id_r;
        occ_nxt        = occ_r + 1'b1;
        if (urg_r) uocc_nxt = uocc_r + 1'b1;
        status_nxt     = 1'b0;
        state_nxt      = S_FIN;
      end

      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // output register: load a finished result, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {2'b00, COUNT_W'(uocc_r), COUNT_W'(occ_r), dep_r, found_r, status_r};
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qtype_r     <= 1'b0;
      occ_r       <= '0;
      uocc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      uocc_r      <= uocc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) qtype_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    urg_r      <= urg_nxt;
    dir_up_r   <= dir_up_nxt;
    hit_urg_r  <= hit_urg_nxt;
    status_r   <= status_nxt;
    found_r    <= found_nxt;
    dep_r      <= dep_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // urgent items are a subset of all queued items
  a_urgent_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    uocc_r <= occ_r)
    else $error("urgent count exceeds total count");

  // occupancy never passes the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(QUEUE_DEPTH))
    else $error("occupancy above queue depth");

  // one operation moves the occupancy by at most one
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 ((occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + 1'b1) ||
         (occ_r + 1'b1 == $past(occ_r))))
    else $error("occupancy jumped by more than one");

  // an accepted transaction closes the input until its result is staged
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("input accepted twice without a result");
`endif

endmodule

### sim/two_class_priority_queue_tb.sv
// two_class_priority_queue_tb: self-checking bench for the two-class priority queue.
// Drives add/depart/remove/lookup transactions, tracks the queue in a shadow copy
// and checks every reply field by field. Depends on tcpq_pkg and the queue RTL.
`timescale 1ns / 1ps

module two_class_priority_queue_tb;
  import tcpq_pkg::*;

  localparam int DEPTH         = 16;
  localparam int IDLE_PCT      = 13;       // chance in 100 that a side idles
  localparam int CALM_FROM     = 4000;     // cycle window with no idling at all
  localparam int CALM_TO       = 14000;
  localparam int SETTLE_CYCLES = 8;        // quiet cycles before a register write
  localparam int PHASE_ITEMS   = 250;
  localparam int NUM_PHASES    = 7;
  localparam int CYCLE_LIMIT   = 900000;

  typedef enum logic {ITEM_OP, ITEM_PHASE} item_kind_t;

  // One entry of the stimulus backlog: an operation, or a phase boundary that
  // drains the queue's reply stream and then rewrites queue_type.
  typedef struct packed {
    item_kind_t           kind;
    logic                 cfg_value;
    op_t                  mode;
    logic [ITEM_ID_W-1:0] item_id;
    logic                 urgent;
    logic                 item_type;
  } backlog_item_t;

  typedef struct packed {
    logic                 status;
    logic                 found;
    logic [ITEM_ID_W-1:0] departed_id;
    logic [COUNT_W-1:0]   total_count;
    logic [COUNT_W-1:0]   urgent_count;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // item_id[9:0], urgent[10], item_type[11], zero pad
  logic [1:0]  in_tuser = '0;    // mode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // status[0], found[1], departed_id[11:2],
                                 // total_count[16:12], urgent_count[21:17], zero pad

  // Shadow copy of the queue contents and of queue_type.
  logic [ITEM_ID_W-1:0] shadow_ids[DEPTH];
  logic                 shadow_urgent[DEPTH];
  int                   shadow_len = 0;
  int                   shadow_urg_len = 0;
  logic                 shadow_type = 1'b0;

  backlog_item_t op_backlog[$];
  backlog_item_t cur_op;
  reply_t        replies_due[$];
  int            ops_sent = 0;       // transactions accepted on the input side
  int            replies_seen = 0;   // replies matched against the shadow queue
  int            n_mismatch = 0;
  int            settle = 0;
  int            cyc = 0;
  logic          gen_type = 1'b0;    // queue_type the generator assumes

  two_class_priority_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Take the entry at pos out of the shadow queue and close the gap.
  function automatic void drop_entry(input int pos);
    if (shadow_urgent[pos]) shadow_urg_len--;
    for (int i = pos; i + 1 < shadow_len; i++) begin
      shadow_ids[i]    = shadow_ids[i + 1];
      shadow_urgent[i] = shadow_urgent[i + 1];
    end
    shadow_len--;
  endfunction

  // Apply one operation to the shadow queue and return the reply it earns.
  function automatic reply_t apply_queue_op(input backlog_item_t op);
    reply_t r;
    int     pos;
    logic   id_ok;
    r        = '0;
    r.status = 1'b1;
    id_ok    = (op.item_id != 0) && (op.item_id <= MAX_ITEM_ID);
    pos      = -1;
    for (int i = 0; i < shadow_len; i++) begin
      if (shadow_ids[i] == op.item_id && pos < 0) pos = i;
    end
    case (op.mode)
      OP_ADD: begin
        if (id_ok && op.item_type == shadow_type && pos < 0 && shadow_len < DEPTH) begin
          // urgent items go right behind the last urgent one, normal ones to the tail
          pos = op.urgent ? shadow_urg_len : shadow_len;
          for (int i = shadow_len; i > pos; i--) begin
            shadow_ids[i]    = shadow_ids[i - 1];
            shadow_urgent[i] = shadow_urgent[i - 1];
          end
          shadow_ids[pos]    = op.item_id;
          shadow_urgent[pos] = op.urgent;
          shadow_len++;
          if (op.urgent) shadow_urg_len++;
          r.status = 1'b0;
        end
      end
      OP_DEPART: begin
        if (shadow_len > 0) begin
          r.departed_id = shadow_ids[0];
          drop_entry(0);
          r.status = 1'b0;
        end
      end
      OP_REMOVE: begin
        if (id_ok && pos >= 0) begin
          drop_entry(pos);
          r.status = 1'b0;
        end
      end
      OP_LOOKUP: begin
        if (id_ok) begin
          r.status = 1'b0;
          r.found  = (pos >= 0);
        end
      end
      default: ;
    endcase
    r.total_count  = shadow_len[COUNT_W-1:0];
    r.urgent_count = shadow_urg_len[COUNT_W-1:0];
    return r;
  endfunction

  task automatic push_op(input op_t mode, input int id, input logic urg, input logic typ);
    backlog_item_t it;
    it           = '0;
    it.kind      = ITEM_OP;
    it.mode      = mode;
    it.item_id   = id[ITEM_ID_W-1:0];
    it.urgent    = urg;
    it.item_type = typ;
    op_backlog.push_back(it);
  endtask

  task automatic push_phase(input logic val);
    backlog_item_t it;
    it           = '0;
    it.kind      = ITEM_PHASE;
    it.cfg_value = val;
    op_backlog.push_back(it);
    gen_type = val;
  endtask

  // Mostly a small id pool so that duplicates, hits on remove and lookup are
  // common; the rest covers zero, the top id and the full range.
  function automatic int pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(40, 1);
    if (r < 80) return 0;
    if (r < 85) return MAX_ITEM_ID;
    return $urandom_range((1 << ITEM_ID_W) - 1, 0);
  endfunction

  task automatic push_random_op(input int style);
    int   r;
    op_t  mode;
    logic typ;
    r = $urandom_range(99);
    // style 0 fills the queue, style 1 is balanced, style 2 drains it
    case (style)
      0:       mode = (r < 55) ? OP_ADD : (r < 65) ? OP_DEPART : (r < 80) ? OP_REMOVE : OP_LOOKUP;
      1:       mode = (r < 35) ? OP_ADD : (r < 55) ? OP_DEPART : (r < 80) ? OP_REMOVE : OP_LOOKUP;
      default: mode = (r < 25) ? OP_ADD : (r < 60) ? OP_DEPART : (r < 85) ? OP_REMOVE : OP_LOOKUP;
    endcase
    typ = ($urandom_range(99) < 90) ? gen_type : ~gen_type;
    push_op(mode, pick_id(), 1'($urandom_range(1)), typ);
  endtask

  // Fill the backlog, then release reset and wait for the run to finish.
  initial begin
    // Directed part, queue_type at its reset value (domestic).
    push_op(OP_DEPART, 0, 1'b0, 1'b0);            // depart on an empty queue
    push_op(OP_REMOVE, 5, 1'b0, 1'b0);            // remove an absent id
    push_op(OP_REMOVE, 0, 1'b1, 1'b1);            // remove with the invalid id
    push_op(OP_LOOKUP, 0, 1'b0, 1'b0);            // lookup with the invalid id
    push_op(OP_LOOKUP, MAX_ITEM_ID, 1'b1, 1'b1);  // lookup of a valid absent id
    push_op(OP_ADD, 0, 1'b0, 1'b0);               // add with the invalid id
    push_op(OP_ADD, MAX_ITEM_ID, 1'b0, 1'b0);     // normal add at the top id
    push_op(OP_ADD, 7, 1'b0, 1'b1);               // type mismatch
    push_op(OP_ADD, 1, 1'b1, 1'b0);               // urgent goes to the front
    push_op(OP_ADD, MAX_ITEM_ID, 1'b1, 1'b0);     // duplicate id
    push_op(OP_ADD, 2, 1'b1, 1'b0);               // second urgent behind the first
    push_op(OP_LOOKUP, MAX_ITEM_ID, 1'b0, 1'b0);  // lookup hit
    push_op(OP_REMOVE, MAX_ITEM_ID, 1'b0, 1'b0);  // remove from the tail
    push_op(OP_DEPART, 0, 1'b1, 1'b1);            // depart the urgent head
    // Fill up with a mix of classes; the last add hits a full queue.
    for (int i = 0; i < DEPTH; i++) begin
      push_op(OP_ADD, 512 + i, (i % 3) == 0, 1'b0);
    end

    // Random phases, alternating queue_type through both values.
    for (int p = 0; p < NUM_PHASES; p++) begin
      push_phase((p % 2) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) push_random_op(p % 3);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so the checks see settled values.
    while (op_backlog.size() != 0 || in_tvalid || ops_sent != replies_seen) begin
      @(negedge clk);
    end
    repeat (4 * DEPTH + 16) @(negedge clk);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Driver: present backlog items on the input stream and apply phase writes.
  always @(posedge clk) begin
    logic          fire;
    logic          hold;
    logic          want_valid;
    logic          want_we;
    backlog_item_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_we    <= 1'b0;
      settle    = 0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        replies_due.push_back(apply_queue_op(cur_op));
        ops_sent <= ops_sent + 1;
      end
      // hold the current transaction until the queue takes it
      hold       = in_tvalid && !fire;
      want_valid = hold;
      want_we    = 1'b0;
      if (!hold && op_backlog.size() != 0) begin
        head = op_backlog[0];
        if (head.kind == ITEM_PHASE) begin
          // Pause the sender until every reply is back, then let the
          // sequencer go quiet before touching queue_type.
          if (fire || ops_sent != replies_seen) begin
            settle = 0;
          end else if (settle < SETTLE_CYCLES) begin
            settle++;
          end else begin
            want_we     = 1'b1;
            cfg_wdata   <= head.cfg_value;
            shadow_type = head.cfg_value;
            op_backlog.delete(0);
            settle = 0;
          end
        end else if ((cyc >= CALM_FROM && cyc < CALM_TO) ||
                     $urandom_range(99) >= IDLE_PCT) begin
          want_valid = 1'b1;
          cur_op     = head;
          in_tdata   <= {4'b0, head.item_type, head.urgent, head.item_id};
          in_tuser   <= head.mode;
          op_backlog.delete(0);
        end
      end
      in_tvalid <= want_valid;
      cfg_we    <= want_we;
    end
  end

  task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
    if (want != got) begin
      n_mismatch++;
      if (n_mismatch <= 10) begin
        $display("reply %0d: %s expected %0d, got %0d", replies_seen, fname, want, got);
      end
    end
  endtask

  // Monitor: take replies with random back-pressure and check each field.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (ops_sent == replies_seen) begin
          // a reply with no transaction behind it
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected reply, data %h", out_tdata);
        end else begin
          want = replies_due.pop_front();
          check_field("status", want.status, out_tdata[0]);
          check_field("found", want.found, out_tdata[1]);
          check_field("departed_id", want.departed_id, out_tdata[11:2]);
          check_field("total_count", want.total_count, out_tdata[16:12]);
          check_field("urgent_count", want.urgent_count, out_tdata[21:17]);
          replies_seen <= replies_seen + 1;
        end
      end
      out_tready <= (cyc >= CALM_FROM && cyc < CALM_TO) || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Cycle counter; stop a hung run.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
